// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/fcct_pkg.sv
package fcct_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 4;
  localparam int unsigned MAX_TICKS_DEF    = 16;
  localparam int unsigned MaxChannels      = 4;

  localparam int unsigned MwControl = 0;
  localparam int unsigned MwReset   = 1;
  localparam int unsigned MwConst   = 2;
  localparam int unsigned MwTrigger = 3;
  localparam int unsigned MwPre256  = 5;
  localparam int unsigned MwCounter = 6;
  localparam int unsigned MwIrq     = 7;

  localparam logic [7:0] ModeResetVal = 8'h02;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_TRIGGER = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef struct packed {
    logic       valid;
    logic       sel;
    op_e        op;
    logic [7:0] data;
    logic [4:0] ticks;
  } chan_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       zero;
    logic       irq;
    logic       loaded;
    logic       vec_ok;
  } chan_rsp_t;

  function automatic logic [17:0] reload_value(input logic [7:0] tc, input logic [7:0] mode);
    logic [8:0] base;
    begin
      base = (tc == 8'd0) ? 9'h100 : {1'b0, tc};
      if (mode[MwCounter]) begin
        reload_value = {9'd0, base};
      end else if (mode[MwPre256]) begin
        reload_value = {1'b0, base, 8'd0};
      end else begin
        reload_value = {5'd0, base, 4'd0};
      end
    end
  endfunction

endpackage

// File: src/four_channel_counter_timer_core.sv
// an input transaction is held in the input register, then in the output register, on its way to the master side
// throughput: one transaction per cycle while the master side accepts, tick transactions included
// all channels update in parallel from one registered pass per transaction
// reset: channels return to the reset mode word with zero constant and count,
// vector base cleared, both pipeline registers emptied
module four_channel_counter_timer_core #(
  parameter int unsigned NumChannels = fcct_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MaxTicks    = fcct_pkg::MAX_TICKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // data[7:0], ticks[12:8], zero
  input  logic [3:0]  s_axis_tuser_i,  // operation[1:0], channel[3:2]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // read_data, zero_count_mask, irq_mask,
                                       // vector_base, channel_loaded, zero
);
  import fcct_pkg::*;

  `include "assert_macros.svh"

  logic       in_valid_q, in_valid_d;
  op_e        in_op_q;
  logic [1:0] in_ch_q;
  logic [7:0] in_data_q;
  logic [4:0] in_ticks_q;
  logic       in_accept;
  logic       advance;
  logic [4:0] ticks_sat;

  logic        out_valid_q, out_valid_d;
  logic [23:0] out_data_q;
  logic [4:0]  vec_q, vec_d;

  chan_cmd_t cmd   [NumChannels];
  chan_rsp_t rsp   [NumChannels];

  logic [7:0]             rd_all;
  logic [MaxChannels-1:0] zero_mask;
  logic [MaxChannels-1:0] irq_mask;
  logic                   loaded;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d     = advance ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  assign ticks_sat = (in_ticks_q > 5'(MaxTicks)) ? 5'(MaxTicks) : in_ticks_q;

  for (genvar c = 0; c < NumChannels; c++) begin : g_chan
    always_comb begin
      cmd[c].valid = advance;
      cmd[c].sel   = (in_ch_q == 2'(c));
      cmd[c].op    = in_op_q;
      cmd[c].data  = in_data_q;
      cmd[c].ticks = ticks_sat;
    end

    fcct_chan u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[c]),
      .rsp_o  (rsp[c])
    );
  end

  always_comb begin
    rd_all    = '0;
    zero_mask = '0;
    irq_mask  = '0;
    loaded    = 1'b0;
    for (int unsigned c = 0; c < NumChannels; c++) begin
      rd_all       = rd_all | rsp[c].read_data;
      zero_mask[c] = rsp[c].zero;
      irq_mask[c]  = rsp[c].irq;
      loaded       = loaded | rsp[c].loaded;
    end
  end

  assign vec_d = (advance && in_op_q == OP_WRITE && in_ch_q == 2'd0 && rsp[0].vec_ok)
                 ? in_data_q[7:3] : vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vec_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      vec_q       <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q    <= op_e'(s_axis_tuser_i[1:0]);
      in_ch_q    <= s_axis_tuser_i[3:2];
      in_data_q  <= s_axis_tdata_i[7:0];
      in_ticks_q <= s_axis_tdata_i[12:8];
    end
    if (advance) begin
      out_data_q <= {2'b00, loaded, vec_d, irq_mask, zero_mask, rd_all};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_q)
  `ASSERT_NEXT(a_stall_keeps_input, clk_i, rst_ni,
               in_valid_q && out_valid_q && !m_axis_tready_i, in_valid_q)
  `ASSERT_IMPLY(a_loaded_no_zero, clk_i, rst_ni,
                out_valid_q && out_data_q[21], out_data_q[15:8] == 8'd0)

endmodule

// File: src/fcct_chan.sv
module fcct_chan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fcct_pkg::chan_cmd_t  cmd_i,
  output fcct_pkg::chan_rsp_t  rsp_o
);
  import fcct_pkg::*;

  `include "assert_macros.svh"

  logic [7:0]  mode_q, mode_d;
  logic [7:0]  tc_q, tc_d;
  logic [17:0] dc_q, dc_d;
  logic        wt_q, wt_d;

  logic        running;
  logic [17:0] reload_cur;
  logic [17:0] reload_new;
  logic [17:0] dec;
  logic signed [19:0] v0, v1, v2, rl;
  logic        fire1, fire2;
  logic        tmr_run;

  assign running    = !mode_q[MwReset] && !mode_q[MwConst];
  assign reload_cur = reload_value(tc_q, mode_q);
  assign reload_new = reload_value(cmd_i.data, mode_q);
  assign dec        = dc_q - 18'd1;
  assign tmr_run    = running && !mode_q[MwCounter] && !wt_q;

  // timer advance: at most two zero crossings per tick transaction
  assign rl    = signed'({2'b00, reload_cur});
  assign v0    = signed'({2'b00, dc_q}) - signed'({15'd0, cmd_i.ticks});
  assign fire1 = (v0 <= 20'sd0);
  assign v1    = fire1 ? (v0 + rl) : v0;
  assign fire2 = fire1 && (v1 <= 20'sd0);
  assign v2    = fire2 ? (v1 + rl) : v1;

  always_comb begin
    mode_d = mode_q;
    tc_d   = tc_q;
    dc_d   = dc_q;
    wt_d   = wt_q;
    rsp_o  = '0;
    rsp_o.vec_ok = !mode_q[MwConst] && !cmd_i.data[MwControl];
    if (cmd_i.valid) begin
      unique case (cmd_i.op)
        OP_WRITE: begin
          if (cmd_i.sel) begin
            if (mode_q[MwConst]) begin
              tc_d = cmd_i.data;
              dc_d = reload_new;
              mode_d[MwConst] = 1'b0;
              mode_d[MwReset] = 1'b0;
              if (!mode_q[MwCounter]) begin
                wt_d = mode_q[MwTrigger];
              end
              rsp_o.loaded = 1'b1;
            end else if (cmd_i.data[MwControl]) begin
              mode_d = cmd_i.data;
              rsp_o.loaded = !cmd_i.data[MwConst];
            end
          end
        end
        OP_READ: begin
          if (cmd_i.sel) begin
            if (mode_q[MwCounter]) begin
              rsp_o.read_data = dc_q[7:0];
            end else if (mode_q[MwPre256]) begin
              rsp_o.read_data = dc_q[15:8];
            end else begin
              rsp_o.read_data = dc_q[11:4];
            end
          end
        end
        OP_TRIGGER: begin
          if (cmd_i.sel && running) begin
            if (mode_q[MwCounter]) begin
              if (dec == 18'd0) begin
                rsp_o.zero = 1'b1;
                rsp_o.irq  = mode_q[MwIrq];
                dc_d       = reload_cur;
              end else begin
                dc_d = dec;
              end
            end
            wt_d = 1'b0;
          end
        end
        OP_TICK: begin
          if (tmr_run) begin
            rsp_o.zero = fire1;
            rsp_o.irq  = fire1 && mode_q[MwIrq];
            dc_d       = v2[17:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeResetVal;
      tc_q   <= '0;
      dc_q   <= '0;
      wt_q   <= 1'b0;
    end else begin
      mode_q <= mode_d;
      tc_q   <= tc_d;
      dc_q   <= dc_d;
      wt_q   <= wt_d;
    end
  end

  `ASSERT_IMPLY(a_irq_needs_zero, clk_i, rst_ni, rsp_o.irq, rsp_o.zero)
  `ASSERT_IMPLY(a_zero_source, clk_i, rst_ni, rsp_o.zero,
                cmd_i.valid && (cmd_i.op == OP_TRIGGER || cmd_i.op == OP_TICK))
  `ASSERT_NEXT(a_const_clears_mode, clk_i, rst_ni,
               cmd_i.valid && cmd_i.sel && cmd_i.op == OP_WRITE && mode_q[MwConst],
               !mode_q[MwConst] && !mode_q[MwReset] && dc_q != 18'd0)

endmodule
